/* hdl/gas_sensor_baseline_classifier_defines.svh */
// assertion macros shared by the gas sensor classifier rtl
`ifndef GAS_SENSOR_BASELINE_CLASSIFIER_DEFINES_SVH
`define GAS_SENSOR_BASELINE_CLASSIFIER_DEFINES_SVH

// implication checked in the same cycle
`define GSBC_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define GSBC_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define GSBC_NEVER(label, cond, msg) \
    `GSBC_IMPL(label, 1'b1, !(cond), msg)

`endif

/* hdl/gsbc_pkg.sv */
// types and constants of the gas sensor baseline classifier
package gsbc_pkg;

    localparam int RAW_W     = 12;
    localparam int PIN_W     = 12;
    localparam int MV_W      = 13;
    localparam int PPM_W     = 23;
    localparam int THR_W     = 23;
    localparam int DVS_W     = 13;
    localparam int NUM_W     = 26;
    localparam int GAIN_W    = 18;
    localparam int CFG_IDX_W = 2;

    localparam int PPM_MAX   = 4990000;
    localparam int MV_GAIN   = 51;
    localparam int PPM_SCALE = 10000;

    localparam logic [DVS_W-1:0] MV_DIV  = 13'd33;
    localparam logic [MV_W-1:0]  MV_MIN  = 13'd10;
    localparam logic [MV_W-1:0]  MV_MAX  = 13'd4990;
    localparam logic [MV_W-1:0]  MV_FULL = 13'd5000;

    localparam logic [THR_W-1:0] WARN_RESET   = 23'd50;
    localparam logic [THR_W-1:0] DANGER_RESET = 23'd80;

    typedef enum logic [1:0] {
        LVL_GOOD    = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_DANGER  = 2'd2
    } level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARNING = 2'd0,
        CFG_DANGER  = 2'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MV_WAIT,
        ST_PPM_START,
        ST_PPM_WAIT,
        ST_ACCUM,
        ST_BASE_WAIT,
        ST_DELTA,
        ST_LEVEL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [THR_W-1:0] warning;
        logic [THR_W-1:0] danger;
    } thr_t;

    typedef struct packed {
        logic             status;
        logic             reading_good;
        logic [RAW_W-1:0] raw_code;
        logic [PIN_W-1:0] pin_mv;
        logic [MV_W-1:0]  sensor_mv;
        logic [PPM_W-1:0] ppm;
        logic [PPM_W-1:0] baseline;
        logic [PPM_W-1:0] delta;
        level_t           level;
        logic             calibrated;
    } result_t;

endpackage

/* hdl/gsbc_if.sv */
// stream and configuration interfaces of the gas sensor classifier
interface gsbc_sample_if;
    import gsbc_pkg::*;

    logic             valid;
    logic             ready;
    logic             read_ok;
    logic [RAW_W-1:0] raw_code;
    logic [PIN_W-1:0] pin_millivolts;

    modport source (output valid, read_ok, raw_code, pin_millivolts, input ready);
    modport sink (input valid, read_ok, raw_code, pin_millivolts, output ready);
endinterface

interface gsbc_result_if;
    import gsbc_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic             reading_good;
    logic [RAW_W-1:0] raw_code_out;
    logic [PIN_W-1:0] pin_millivolts_out;
    logic [MV_W-1:0]  sensor_millivolts;
    logic [PPM_W-1:0] ppm_estimate;
    logic [PPM_W-1:0] baseline_ppm;
    logic [PPM_W-1:0] excess_ppm;
    logic [1:0]       level;
    logic             calibrated;

    modport source (
        output valid, status, reading_good, raw_code_out, pin_millivolts_out,
               sensor_millivolts, ppm_estimate, baseline_ppm, excess_ppm, level, calibrated,
        input  ready
    );
    modport sink (
        input  valid, status, reading_good, raw_code_out, pin_millivolts_out,
               sensor_millivolts, ppm_estimate, baseline_ppm, excess_ppm, level, calibrated,
        output ready
    );
endinterface

interface gsbc_cfg_if;
    import gsbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/gsbc_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
`include "gas_sensor_baseline_classifier_defines.svh"

module gsbc_divider #(
    parameter int DIV_W = 26
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIV_W-1:0]         dividend,
    input  logic [gsbc_pkg::DVS_W-1:0] divisor,
    output gsbc_pkg::div_stat_t      stat,
    output logic [DIV_W-1:0]         quot
);
    import gsbc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = (cnt_reg == CNT_W'(1)) && !start;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            q_next   = {q_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quot      = q_reg;

    `GSBC_IMPL(a_rem_below_dvs, stat.busy && dvs_reg != '0, rem_reg < dvs_reg, "remainder not below divisor")
    `GSBC_NEVER(a_start_when_busy, start && stat.busy, "divider restarted while busy")
    `GSBC_IMPL(a_done_when_idle, done_reg, cnt_reg == '0, "done raised with steps left")

endmodule

/* hdl/gsbc_ctrl.sv */
// sequencer, calibration and classification state of the classifier
`include "gas_sensor_baseline_classifier_defines.svh"

module gsbc_ctrl #(
    parameter int CAL_SAMPLES = 5,
    parameter int SUM_W       = 25,
    parameter int DIV_W       = 26
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gsbc_sample_if.sink                sample,
    input  gsbc_pkg::thr_t             thr,
    input  logic                       out_free,
    output logic                       load,
    output gsbc_pkg::result_t          res,
    output logic                       div_start,
    output logic [DIV_W-1:0]           div_dividend,
    output logic [gsbc_pkg::DVS_W-1:0] div_divisor,
    input  gsbc_pkg::div_stat_t        div_stat,
    input  logic [DIV_W-1:0]           div_quot
);
    import gsbc_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    ctrl_state_t      state_reg, state_next;
    logic             status_reg, status_next;
    logic             ok_reg, ok_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic [PIN_W-1:0] pin_reg, pin_next;
    logic [MV_W-1:0]  mv_reg, mv_next;
    logic [PPM_W-1:0] ppm_reg, ppm_next;
    logic [PPM_W-1:0] base_reg, base_next;
    logic [PPM_W-1:0] delta_reg, delta_next;
    level_t           level_reg, level_next;
    logic             cal_reg, cal_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             accept;
    logic [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0] cnt_inc;
    logic             cal_last;

    assign accept   = sample.valid && sample.ready;
    assign sum_add  = sum_reg + SUM_W'(ppm_reg);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cal_last = cnt_inc == CNT_W'(CAL_SAMPLES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = sample.read_ok ? ST_MV_WAIT : ST_DONE;
            ST_MV_WAIT:
                if (div_stat.done)
                    state_next = ST_PPM_START;
            ST_PPM_START:
                state_next = ST_PPM_WAIT;
            ST_PPM_WAIT:
                if (div_stat.done)
                    state_next = cal_reg ? ST_DELTA : ST_ACCUM;
            ST_ACCUM:
                state_next = cal_last ? ST_BASE_WAIT : ST_DONE;
            ST_BASE_WAIT:
                if (div_stat.done)
                    state_next = ST_DONE;
            ST_DELTA:
                state_next = ST_LEVEL;
            ST_LEVEL:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        sample.ready = 1'b0;
        load         = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(GAIN_W'(sample.pin_millivolts) * GAIN_W'(MV_GAIN));
        div_divisor  = MV_DIV;
        case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                div_start    = accept && sample.read_ok;
            end
            ST_PPM_START:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(NUM_W'(mv_reg) * NUM_W'(PPM_SCALE));
                div_divisor  = MV_FULL - mv_reg;
            end
            ST_ACCUM:
            begin
                div_start    = cal_last;
                div_dividend = DIV_W'(sum_add);
                div_divisor  = DVS_W'(CAL_SAMPLES);
            end
            ST_DONE:
                load = out_free;
            default:
                load = 1'b0;
        endcase
    end

    // held data
    always_comb
    begin
        status_next = status_reg;
        ok_next     = ok_reg;
        raw_next    = raw_reg;
        pin_next    = pin_reg;
        mv_next     = mv_reg;
        ppm_next    = ppm_reg;
        base_next   = base_reg;
        delta_next  = delta_reg;
        level_next  = level_reg;
        cal_next    = cal_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    status_next = !sample.read_ok;
                    if (sample.read_ok)
                    begin
                        raw_next = sample.raw_code;
                        pin_next = sample.pin_millivolts;
                    end
                    else
                        ok_next = 1'b0;
                end
            ST_MV_WAIT:
                if (div_stat.done)
                begin
                    if (div_quot < DIV_W'(MV_MIN))
                        mv_next = MV_MIN;
                    else if (div_quot > DIV_W'(MV_MAX))
                        mv_next = MV_MAX;
                    else
                        mv_next = div_quot[MV_W-1:0];
                end
            ST_PPM_WAIT:
                if (div_stat.done)
                begin
                    ppm_next = div_quot[PPM_W-1:0];
                    ok_next  = 1'b1;
                end
            ST_ACCUM:
            begin
                sum_next   = sum_add;
                cnt_next   = cnt_inc;
                delta_next = '0;
                level_next = LVL_GOOD;
            end
            ST_BASE_WAIT:
                if (div_stat.done)
                begin
                    base_next = div_quot[PPM_W-1:0];
                    cal_next  = 1'b1;
                end
            ST_DELTA:
                delta_next = (ppm_reg > base_reg) ? ppm_reg - base_reg : '0;
            ST_LEVEL:
            begin
                if (delta_reg >= thr.danger)
                    level_next = LVL_DANGER;
                else if (delta_reg >= thr.warning)
                    level_next = LVL_WARNING;
                else
                    level_next = LVL_GOOD;
            end
            default:
                cal_next = cal_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            status_reg <= 1'b0;
            ok_reg     <= 1'b0;
            raw_reg    <= '0;
            pin_reg    <= '0;
            mv_reg     <= '0;
            ppm_reg    <= '0;
            base_reg   <= '0;
            delta_reg  <= '0;
            level_reg  <= LVL_GOOD;
            cal_reg    <= 1'b0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            ok_reg     <= ok_next;
            raw_reg    <= raw_next;
            pin_reg    <= pin_next;
            mv_reg     <= mv_next;
            ppm_reg    <= ppm_next;
            base_reg   <= base_next;
            delta_reg  <= delta_next;
            level_reg  <= level_next;
            cal_reg    <= cal_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign res.status       = status_reg;
    assign res.reading_good = ok_reg;
    assign res.raw_code     = raw_reg;
    assign res.pin_mv       = pin_reg;
    assign res.sensor_mv    = mv_reg;
    assign res.ppm          = ppm_reg;
    assign res.baseline     = base_reg;
    assign res.delta        = delta_reg;
    assign res.level        = level_reg;
    assign res.calibrated   = cal_reg;

    `GSBC_NEXT(a_cal_sticky, cal_reg, cal_reg, "calibration flag dropped")
    `GSBC_IMPL(a_cnt_bound, !cal_reg, cnt_reg <= CNT_W'(CAL_SAMPLES), "calibration count overran")
    `GSBC_IMPL(a_uncal_good, !cal_reg, delta_reg == '0 && level_reg == LVL_GOOD, "level set before calibration")
    `GSBC_IMPL(a_div_done_wait, div_stat.done, state_reg == ST_MV_WAIT || state_reg == ST_PPM_WAIT || state_reg == ST_BASE_WAIT, "divider finished outside a wait state")

endmodule

/* hdl/gas_sensor_baseline_classifier.sv */
// a failed read goes straight to the result; a good read runs the voltage and ppm
// divisions, then delta and level once calibrated, or accumulation while calibrating,
// plus the average division on the read that completes calibration (DIV_W is 26 at
// the default CAL_SAMPLES); the next reading is taken only once the result is loaded
// the pace is set by the shared one-bit-per-cycle divider for voltage, ppm and average
// reset sets thresholds to 50 and 80 and clears calibration and ctrl fields, not out_reg
module gas_sensor_baseline_classifier #(
    parameter int CAL_SAMPLES = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    gsbc_sample_if.sink    sample,
    gsbc_result_if.source  result,
    gsbc_cfg_if.sink       cfg
);
    import gsbc_pkg::*;

    localparam int SUM_W = $clog2(PPM_MAX * CAL_SAMPLES + 1);
    localparam int DIV_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

    thr_t             thr_reg, thr_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    result_t          res;
    logic             load;
    logic             out_free;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    div_stat_t        div_stat;
    logic [DIV_W-1:0] div_quot;

    // threshold registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WARNING: thr_next.warning = cfg.data;
                CFG_DANGER:  thr_next.danger  = cfg.data;
                default:     thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.warning <= WARN_RESET;
            thr_reg.danger  <= DANGER_RESET;
        end
        else
            thr_reg <= thr_next;
    end

    gsbc_ctrl #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SUM_W       (SUM_W),
        .DIV_W       (DIV_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .thr          (thr_reg),
        .out_free     (out_free),
        .load         (load),
        .res          (res),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_quot     (div_quot)
    );

    gsbc_divider #(
        .DIV_W (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // output register
    assign out_free       = !out_valid_reg || result.ready;
    assign out_valid_next = load || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

    assign result.valid              = out_valid_reg;
    assign result.status             = out_reg.status;
    assign result.reading_good       = out_reg.reading_good;
    assign result.raw_code_out       = out_reg.raw_code;
    assign result.pin_millivolts_out = out_reg.pin_mv;
    assign result.sensor_millivolts  = out_reg.sensor_mv;
    assign result.ppm_estimate       = out_reg.ppm;
    assign result.baseline_ppm       = out_reg.baseline;
    assign result.excess_ppm         = out_reg.delta;
    assign result.level              = out_reg.level;
    assign result.calibrated         = out_reg.calibrated;

endmodule
